### rtl/mct_pkg.sv
// Shared types and constants for the multiplexed countdown timers.
package mct_pkg;

  // Number of timer slots and the index width that follows from it.
  localparam int CAPACITY = 16;
  localparam int SLOT_W   = $clog2(CAPACITY);

  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [15:0]       task_t;
  typedef logic [15:0]       tick_t;
  typedef logic [1:0]        kind_t;

  localparam slot_t LAST_SLOT = slot_t'(CAPACITY - 1);

  // Request operations.
  localparam logic OP_ADD  = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // Result kinds.
  localparam kind_t KIND_EXPIRED  = 2'd0;
  localparam kind_t KIND_ACCEPTED = 2'd1;
  localparam kind_t KIND_REJECTED = 2'd2;

  // Access group from the sequencer to the slot memory.
  typedef struct packed {
    logic  wr_en;
    slot_t wr_addr;
    tick_t wr_rem;
    task_t wr_owner;
    logic  rd_en;
    slot_t rd_addr;
  } ram_req_t;

  // Registered read data of the slot memory.
  typedef struct packed {
    tick_t rem;
    task_t owner;
  } ram_rdata_t;

endpackage

### rtl/mct_slot_ram.sv
// Slot memory holding remaining tick counts and owner task ids.
module mct_slot_ram (
  input  logic               clk,
  input  mct_pkg::ram_req_t  req,
  output mct_pkg::ram_rdata_t rdata
);
  import mct_pkg::*;

  tick_t rem_mem   [CAPACITY];
  task_t owner_mem [CAPACITY];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      rem_mem[req.wr_addr]   <= req.wr_rem;
      owner_mem[req.wr_addr] <= req.wr_owner;
    end
    if (req.rd_en) begin
      rdata.rem   <= rem_mem[req.rd_addr];
      rdata.owner <= owner_mem[req.rd_addr];
    end
  end

endmodule

### rtl/mct_seq.sv
// Sequencer with the shared decrement unit, slot busy bits and output register.
module mct_seq (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [31:0]          s_tdata,
  input  logic                 s_tuser,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [15:0]          m_tdata,
  output logic [1:0]           m_tuser,
  output logic                 m_tlast,
  output mct_pkg::ram_req_t    ram_req,
  input  mct_pkg::ram_rdata_t  ram_rdata
);
  import mct_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RESP,
    S_SCAN_RD,
    S_SCAN_WR,
    S_FLUSH
  } state_t;

  state_t              state;
  slot_t               idx;
  logic [CAPACITY-1:0] slot_busy;
  logic                held_valid;
  task_t               held_task;
  kind_t               resp_kind;
  task_t               resp_task;

  logic  op;
  task_t in_task;
  tick_t in_delay;
  logic  full;
  slot_t free_slot;
  logic  accept;
  logic  add_store;
  logic  out_free;
  tick_t dec;
  logic  dec_zero;
  logic  proceed;
  logic  out_load;

  assign op       = s_tuser;
  assign in_task  = s_tdata[15:0];
  assign in_delay = s_tdata[31:16];
  assign full     = &slot_busy;
  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  // An add with a nonzero delay and a free slot takes a slot.
  assign add_store = accept && (op == OP_ADD) && (in_delay != '0) && !full;

  // Lowest free slot.
  always_comb begin
    free_slot = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (!slot_busy[i]) free_slot = slot_t'(i);
    end
  end

  // Shared decrement and zero compare on the slot just read.
  assign dec      = ram_rdata.rem - 16'd1;
  assign dec_zero = (dec == '0);

  // An expiry with one already held must hand the held one to the output first.
  assign proceed = !(dec_zero && held_valid) || out_free;

  // The output register takes a new result in this cycle.
  assign out_load = (state == S_RESP && out_free)
                 || (state == S_SCAN_WR && proceed && dec_zero && held_valid)
                 || (state == S_FLUSH && held_valid && out_free);

  // Memory port control.
  always_comb begin
    ram_req = '0;
    if (add_store) begin
      ram_req.wr_en    = 1'b1;
      ram_req.wr_addr  = free_slot;
      ram_req.wr_rem   = in_delay;
      ram_req.wr_owner = in_task;
    end else if (state == S_SCAN_WR && proceed) begin
      ram_req.wr_en    = 1'b1;
      ram_req.wr_addr  = idx;
      ram_req.wr_rem   = dec;
      ram_req.wr_owner = ram_rdata.owner;
    end
    ram_req.rd_en   = (state == S_SCAN_RD) && slot_busy[idx];
    ram_req.rd_addr = idx;
  end

  // State, busy bits, held expiry and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      slot_busy  <= '0;
      held_valid <= 1'b0;
      m_tvalid   <= 1'b0;
      idx        <= '0;
    end else begin
      if (m_tvalid && m_tready && !out_load) m_tvalid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            resp_task <= in_task;
            if (op == OP_TICK) begin
              idx        <= '0;
              held_valid <= 1'b0;
              state      <= S_SCAN_RD;
            end else begin
              if (in_delay == '0) begin
                resp_kind <= KIND_EXPIRED;
              end else if (full) begin
                resp_kind <= KIND_REJECTED;
              end else begin
                resp_kind            <= KIND_ACCEPTED;
                slot_busy[free_slot] <= 1'b1;
              end
              state <= S_RESP;
            end
          end
        end
        S_RESP: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tdata  <= resp_task;
            m_tuser  <= resp_kind;
            m_tlast  <= 1'b1;
            state    <= S_IDLE;
          end
        end
        S_SCAN_RD: begin
          if (slot_busy[idx]) begin
            state <= S_SCAN_WR;
          end else if (idx == LAST_SLOT) begin
            state <= S_FLUSH;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_SCAN_WR: begin
          if (proceed) begin
            if (dec_zero) begin
              slot_busy[idx] <= 1'b0;
              held_valid     <= 1'b1;
              held_task      <= ram_rdata.owner;
              if (held_valid) begin
                m_tvalid <= 1'b1;
                m_tdata  <= held_task;
                m_tuser  <= KIND_EXPIRED;
                m_tlast  <= 1'b0;
              end
            end
            if (idx == LAST_SLOT) begin
              state <= S_FLUSH;
            end else begin
              idx   <= idx + 1'b1;
              state <= S_SCAN_RD;
            end
          end
        end
        S_FLUSH: begin
          if (!held_valid) begin
            state <= S_IDLE;
          end else if (out_free) begin
            m_tvalid   <= 1'b1;
            m_tdata    <= held_task;
            m_tuser    <= KIND_EXPIRED;
            m_tlast    <= 1'b1;
            held_valid <= 1'b0;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // A new request is only taken once the previous tick has drained its held expiry.
  a_idle_no_held: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !held_valid)
    else $error("request taken while an expiry is still held");

  // A stored add occupies exactly one more slot.
  a_add_takes_slot: assert property (@(posedge clk) disable iff (rst)
    add_store |=> $countones(slot_busy) == $past($countones(slot_busy)) + 1)
    else $error("add did not occupy exactly one slot");

  // Outside of accepting a request the busy set never grows.
  a_scan_no_grow: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |=> $countones(slot_busy) <= $past($countones(slot_busy)))
    else $error("busy slots grew during a scan or response");

  // Flushing the held expiry ends the tick with a marked final result.
  a_flush_last: assert property (@(posedge clk) disable iff (rst)
    (state == S_FLUSH && held_valid && out_free) |=> m_tvalid && m_tlast)
    else $error("final expiry of a tick not marked last");

endmodule

### rtl/multiplexed_countdown_timers.sv
// Top level of the multiplexed countdown timers.
//
// Requests arrive on the s_ channel: s_tuser is the operation (add or tick),
// s_tdata carries the task id and delay. Results leave on the m_ channel:
// m_tuser is the result kind, m_tdata the task id, m_tlast marks the final
// result of a request. Every request gives at least one result except a tick
// on which no timer expires.
// An add's result is loaded into the output register from the response state
// once that register is free, and the block is ready again at the same edge;
// the slot is chosen by a lowest-free search over the busy bits. A tick walks
// the slots one at a time through the single decrement unit: a free slot is
// only checked, a busy one is read from memory and then decremented and
// written back, and a final state hands out any held expiry.
// Requests are taken one at a time; s_tready is high only between requests.
// The output register holds a result until taken. A stalled receiver holds up
// an add's answer and the final expiry of a tick while that register is full,
// and stalls the scan only when a second expiry is ready to be reported.
// Reset clears all busy slots and empties the output; no clearing pass runs.
module multiplexed_countdown_timers (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [15:0] task_id, [31:16] delay_ticks
  input  logic        s_tuser,   // [0] operation
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [15:0] task_id
  output logic [1:0]  m_tuser,   // [1:0] kind
  output logic        m_tlast
);
  import mct_pkg::*;

  ram_req_t   ram_req;
  ram_rdata_t ram_rdata;

  // Control and the shared decrement unit.
  mct_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .ram_req   (ram_req),
    .ram_rdata (ram_rdata)
  );

  // Per-slot counts and owners.
  mct_slot_ram u_ram (
    .clk   (clk),
    .req   (ram_req),
    .rdata (ram_rdata)
  );

endmodule
